// ===== design/lal_pkg.sv =====
`default_nettype none

package lal_pkg;

    // Number formats.
    localparam int FRAC_BITS  = 16;
    localparam int MAX_PIXELS = 4194304;
    localparam int CHAN_W     = 24;
    localparam int OUT_W      = 24;
    localparam int PIX_W      = 23;

    // Rec.709 luminance weights in Q0.16; they sum to 1.0.
    localparam int WEIGHT_W = 16;
    localparam logic [WEIGHT_W-1:0] W_RED   = 16'd13933;
    localparam logic [WEIGHT_W-1:0] W_GREEN = 16'd46871;
    localparam logic [WEIGHT_W-1:0] W_BLUE  = 16'd4732;

    // Luminance accumulator and log2 argument.
    localparam int LUM_W = CHAN_W + WEIGHT_W + 1;
    localparam int X_W   = CHAN_W + 1;

    // Mantissa format of the log2 and exp2 units: Q2.30 in 32 bits.
    localparam int Q_FRAC = 30;
    localparam int Q_W    = 32;

    // Signed log2 value: integer part and FRAC_BITS fraction bits.
    localparam int LOG_INT_W = 6;
    localparam int LOG_W     = LOG_INT_W + FRAC_BITS;

    // Frame accumulators and the mean divider.
    localparam int TALLY_W = $clog2(MAX_PIXELS + 1);
    localparam int SUM_W   = LOG_W + TALLY_W;
    localparam int NUM_W   = SUM_W + 2;
    localparam int DEN_W   = TALLY_W + 1;
    localparam int CNT_W   = $clog2(NUM_W + 1);
    localparam int FIDX_W  = $clog2(FRAC_BITS);

    // Queue between the log2 front end and the frame back end.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam logic [OUT_W-1:0] OUT_MAX = {OUT_W{1'b1}};

    // One log2 result on its way to the frame accumulator.
    typedef struct packed {
        logic [LOG_W-1:0] log_val;
        logic             last;
    } t_mid_item;

    // Entry j holds 2^(2^-(FRAC_BITS-j)) in Q2.30, so it pairs with bit j of the fraction.
    typedef logic [FRAC_BITS-1:0][Q_W-1:0] t_exp_tab;

    // Repeated truncating integer square roots starting from 2.0.
    function automatic t_exp_tab exp_tab_build();
        t_exp_tab    tab;
        logic [63:0] c;
        logic [63:0] v;
        logic [63:0] res;
        logic [63:0] bt;
        c = 64'd1 << (Q_FRAC + 1);
        for (int k = 1; k <= FRAC_BITS; k++) begin
            v   = c << Q_FRAC;
            res = '0;
            for (int j = 31; j >= 0; j--) begin
                bt = 64'd1 << (2 * j);
                if (v >= res + bt) begin
                    v   = v - (res + bt);
                    res = (res >> 1) + bt;
                end else begin
                    res = res >> 1;
                end
            end
            c = res;
            tab[FRAC_BITS-k] = c[Q_W-1:0];
        end
        return tab;
    endfunction

    localparam t_exp_tab EXP_TAB = exp_tab_build();

endpackage

`default_nettype wire

// ===== design/lal_front.sv =====
`default_nettype none

module lal_front (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    input  logic [lal_pkg::CHAN_W-1:0] i_red,
    input  logic [lal_pkg::CHAN_W-1:0] i_green,
    input  logic [lal_pkg::CHAN_W-1:0] i_blue,
    input  logic                       i_last_pixel,
    output logic                       o_full,
    output logic                       o_q_push,
    input  logic                       i_q_full,
    output lal_pkg::t_mid_item         o_q_item
);
    import lal_pkg::*;

    localparam int NORM_STEPS = $clog2(Q_FRAC + 1);
    localparam int LEAD_W     = NORM_STEPS;
    localparam int STEP_W     = $clog2(FRAC_BITS);
    localparam int PROD_W     = CHAN_W + WEIGHT_W;
    localparam logic [LEAD_W-1:0] SH_FIRST   = LEAD_W'(1 << (NORM_STEPS - 1));
    localparam logic [LEAD_W-1:0] MANT_TOP   = LEAD_W'(Q_FRAC + 1);
    localparam logic [LUM_W-1:0]  ROUND_HALF = LUM_W'(1 << (WEIGHT_W - 1));

    typedef enum logic [2:0] {
        F_IDLE,
        F_LUM,
        F_ROUND,
        F_NORM,
        F_SQR,
        F_PUSH
    } t_fstate;

    t_fstate               r_state;
    logic [CHAN_W-1:0]     r_red;
    logic [CHAN_W-1:0]     r_green;
    logic [CHAN_W-1:0]     r_blue;
    logic                  r_last;
    logic [STEP_W-1:0]     r_step;
    logic [LUM_W-1:0]      r_acc;
    logic [Q_W-1:0]        r_m;
    logic [LEAD_W-1:0]     r_lead;
    logic [FRAC_BITS-1:0]  r_frac;

    logic [CHAN_W-1:0]     mul_chan;
    logic [WEIGHT_W-1:0]   mul_w;
    logic [PROD_W-1:0]     lum_prod;
    logic [LUM_W-1:0]      n_acc;
    logic [X_W-1:0]        lum_x;
    logic [LEAD_W-1:0]     sh;
    logic                  top_zero;
    logic [2*Q_W-1:0]      sq;
    logic [Q_W-1:0]        sq_mant;
    logic [LOG_INT_W-1:0]  log_int;

    // One weight multiply per cycle, red then green then blue.
    always_comb begin
        case (r_step[1:0])
            2'd0: begin
                mul_chan = r_red;
                mul_w    = W_RED;
            end
            2'd1: begin
                mul_chan = r_green;
                mul_w    = W_GREEN;
            end
            default: begin
                mul_chan = r_blue;
                mul_w    = W_BLUE;
            end
        endcase
    end

    assign lum_prod = PROD_W'(mul_chan) * PROD_W'(mul_w);
    assign n_acc    = r_acc + LUM_W'(lum_prod);
    assign lum_x    = r_acc[LUM_W-2:WEIGHT_W] + X_W'(1);

    // Binary-search normalizer: shifts of 16, 8, 4, 2, 1 bring the leading one to bit 30.
    assign sh       = SH_FIRST >> r_step;
    assign top_zero = ((r_m[Q_FRAC:0] >> (MANT_TOP - sh)) == '0);

    // Squaring step of the bit-by-bit log2 fraction.
    assign sq      = (2*Q_W)'(r_m) * (2*Q_W)'(r_m);
    assign sq_mant = sq[Q_FRAC+Q_W-1:Q_FRAC];

    assign log_int = LOG_INT_W'(Q_FRAC - FRAC_BITS) - LOG_INT_W'(r_lead);

    assign o_full           = (r_state != F_IDLE);
    assign o_q_push         = (r_state == F_PUSH);
    assign o_q_item.log_val = {log_int, r_frac};
    assign o_q_item.last    = r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
            r_step  <= '0;
        end else begin
            case (r_state)
                F_IDLE: begin
                    if (i_push) begin
                        r_red   <= i_red;
                        r_green <= i_green;
                        r_blue  <= i_blue;
                        r_last  <= i_last_pixel;
                        r_acc   <= ROUND_HALF;
                        r_step  <= '0;
                        r_state <= F_LUM;
                    end
                end
                F_LUM: begin
                    r_acc  <= n_acc;
                    r_step <= r_step + STEP_W'(1);
                    if (r_step == STEP_W'(2)) begin
                        r_state <= F_ROUND;
                    end
                end
                F_ROUND: begin
                    r_m     <= Q_W'(lum_x);
                    r_lead  <= '0;
                    r_step  <= '0;
                    r_state <= F_NORM;
                end
                F_NORM: begin
                    if (top_zero) begin
                        r_m    <= r_m << sh;
                        r_lead <= r_lead + sh;
                    end
                    if (r_step == STEP_W'(NORM_STEPS - 1)) begin
                        r_step  <= '0;
                        r_state <= F_SQR;
                    end else begin
                        r_step <= r_step + STEP_W'(1);
                    end
                end
                F_SQR: begin
                    if (sq_mant[Q_W-1]) begin
                        r_m <= sq_mant >> 1;
                    end else begin
                        r_m <= sq_mant;
                    end
                    r_frac <= {r_frac[FRAC_BITS-2:0], sq_mant[Q_W-1]};
                    r_step <= r_step + STEP_W'(1);
                    if (r_step == STEP_W'(FRAC_BITS - 1)) begin
                        r_state <= F_PUSH;
                    end
                end
                F_PUSH: begin
                    if (!i_q_full) begin
                        r_state <= F_IDLE;
                    end
                end
                default: begin
                    r_state <= F_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== design/lal_queue.sv =====
`default_nettype none

module lal_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  lal_pkg::t_mid_item i_item,
    output logic               o_full,
    input  logic               i_pop,
    output lal_pkg::t_mid_item o_item,
    output logic               o_empty
);
    import lal_pkg::*;

    t_mid_item          r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  r_wr;
    logic [QPTR_W-1:0]  r_rd;
    logic [QPTR_W:0]    r_count;

    logic do_push;
    logic do_pop;

    assign o_full  = (r_count == (QPTR_W+1)'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_item  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= r_wr + QPTR_W'(1);
            end
            if (do_pop) begin
                r_rd <= r_rd + QPTR_W'(1);
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + (QPTR_W+1)'(1);
                2'b01:   r_count <= r_count - (QPTR_W+1)'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== design/lal_back.sv =====
`default_nettype none

module lal_back (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  lal_pkg::t_mid_item        i_q_item,
    input  logic                      i_q_empty,
    output logic                      o_q_pop,
    input  logic                      i_pop,
    output logic                      o_empty,
    output logic [lal_pkg::OUT_W-1:0] o_average_luminance,
    output logic [lal_pkg::PIX_W-1:0] o_frame_pixels
);
    import lal_pkg::*;

    localparam int T_W         = 8;
    localparam int EXP_SAT_T   = 6;
    localparam int EXP_ZERO_T  = 40;
    localparam int RND_W       = EXP_ZERO_T + 2;
    localparam int TSH_W       = $clog2(EXP_ZERO_T + 1);
    localparam logic [2*Q_W-1:0] MUL_HALF = (2*Q_W)'(1) << (Q_FRAC - 1);

    typedef enum logic [2:0] {
        B_IDLE,
        B_PREP,
        B_DIV,
        B_FIX,
        B_EXP,
        B_SCALE
    } t_bstate;

    t_bstate                   r_state;
    logic signed [SUM_W-1:0]   r_sum;
    logic [TALLY_W-1:0]        r_tally;
    logic                      r_neg;
    logic [NUM_W-1:0]          r_quo;
    logic [DEN_W-1:0]          r_rem;
    logic [DEN_W-1:0]          r_den;
    logic [CNT_W-1:0]          r_cnt;
    logic [LOG_W-1:0]          r_mean;
    logic [Q_W-1:0]            r_exp;
    logic [PIX_W-1:0]          r_pixels;
    logic                      r_out_valid;
    logic [OUT_W-1:0]          r_avg;
    logic [PIX_W-1:0]          r_out_pixels;

    logic                      take;
    logic signed [SUM_W-1:0]   log_ext;
    logic [NUM_W-1:0]          sum_ext;
    logic [NUM_W-1:0]          num;
    logic [NUM_W-1:0]          mag;
    logic [DEN_W:0]            trial;
    logic [DEN_W:0]            diff;
    logic                      ge;
    logic [DEN_W-1:0]          n_rem;
    logic [LOG_W-1:0]          uq;
    logic [LOG_W-1:0]          n_mean;
    logic [FRAC_BITS-1:0]      mean_f;
    logic [FIDX_W-1:0]         fidx;
    logic [2*Q_W-1:0]          exp_prod;
    logic [Q_W-1:0]            n_exp;
    logic [LOG_INT_W-1:0]      mean_i;
    logic signed [T_W-1:0]     t;
    logic [TSH_W-1:0]          t_sh;
    logic [RND_W-1:0]          rnd_sum;
    logic [RND_W-1:0]          shifted;
    logic [OUT_W-1:0]          scaled;
    logic [OUT_W-1:0]          n_avg;
    logic                      load_out;

    assign o_q_pop = (r_state == B_IDLE) && !i_q_empty;
    assign take    = (r_tally < TALLY_W'(MAX_PIXELS));
    assign log_ext = SUM_W'($signed(i_q_item.log_val));

    // Rounded mean as a floor division: (2*sum + n) / (2*n).
    assign sum_ext = NUM_W'(r_sum);
    assign num     = {sum_ext[NUM_W-2:0], 1'b0} + NUM_W'(r_tally);
    assign mag     = num[NUM_W-1] ? (~num + NUM_W'(1)) : num;

    // Restoring divider, one quotient bit per cycle.
    assign trial = {r_rem, r_quo[NUM_W-1]};
    assign diff  = trial - {1'b0, r_den};
    assign ge    = (trial >= {1'b0, r_den});
    assign n_rem = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];

    // Floor of a negative quotient: -q when exact, otherwise -q - 1.
    assign uq     = r_quo[LOG_W-1:0];
    assign n_mean = !r_neg ? uq : ((r_rem == '0) ? ('0 - uq) : ~uq);

    // exp2 fraction: one table multiply per cycle, most significant bit first.
    assign mean_f   = r_mean[FRAC_BITS-1:0];
    assign fidx     = r_cnt[FIDX_W-1:0];
    assign exp_prod = (2*Q_W)'(r_exp) * (2*Q_W)'(EXP_TAB[fidx]) + MUL_HALF;
    assign n_exp    = exp_prod[Q_FRAC+Q_W-1:Q_FRAC];

    // Scale by 2^i: right shift by t = 30 - FRAC_BITS - i with round half up.
    assign mean_i  = r_mean[LOG_W-1:FRAC_BITS];
    assign t       = T_W'(Q_FRAC - FRAC_BITS) - T_W'($signed(mean_i));
    assign t_sh    = t[TSH_W-1:0];
    assign rnd_sum = RND_W'(r_exp) + (RND_W'(1) << (t_sh - TSH_W'(1)));
    assign shifted = rnd_sum >> t_sh;
    assign scaled  = (shifted > RND_W'(OUT_MAX)) ? OUT_MAX : shifted[OUT_W-1:0];

    always_comb begin
        if (t <= T_W'(EXP_SAT_T)) begin
            n_avg = OUT_MAX;
        end else if (t > T_W'(EXP_ZERO_T)) begin
            n_avg = '0;
        end else begin
            n_avg = scaled;
        end
    end

    assign load_out = (r_state == B_SCALE) && (!r_out_valid || i_pop);

    assign o_empty             = !r_out_valid;
    assign o_average_luminance = r_avg;
    assign o_frame_pixels      = r_out_pixels;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_sum       <= '0;
            r_tally     <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_pop && r_out_valid && !load_out) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                B_IDLE: begin
                    if (!i_q_empty) begin
                        if (take) begin
                            r_sum   <= r_sum + log_ext;
                            r_tally <= r_tally + TALLY_W'(1);
                        end
                        if (i_q_item.last) begin
                            r_state <= B_PREP;
                        end
                    end
                end
                B_PREP: begin
                    r_neg    <= num[NUM_W-1];
                    r_quo    <= mag;
                    r_den    <= {r_tally, 1'b0};
                    r_rem    <= '0;
                    r_cnt    <= CNT_W'(NUM_W - 1);
                    r_pixels <= PIX_W'(r_tally);
                    r_sum    <= '0;
                    r_tally  <= '0;
                    r_state  <= B_DIV;
                end
                B_DIV: begin
                    r_quo <= {r_quo[NUM_W-2:0], ge};
                    r_rem <= n_rem;
                    if (r_cnt == '0) begin
                        r_state <= B_FIX;
                    end else begin
                        r_cnt <= r_cnt - CNT_W'(1);
                    end
                end
                B_FIX: begin
                    r_mean  <= n_mean;
                    r_exp   <= Q_W'(1) << Q_FRAC;
                    r_cnt   <= CNT_W'(FRAC_BITS - 1);
                    r_state <= B_EXP;
                end
                B_EXP: begin
                    if (mean_f[fidx]) begin
                        r_exp <= n_exp;
                    end
                    if (r_cnt == '0) begin
                        r_state <= B_SCALE;
                    end else begin
                        r_cnt <= r_cnt - CNT_W'(1);
                    end
                end
                B_SCALE: begin
                    if (load_out) begin
                        r_avg        <= n_avg;
                        r_out_pixels <= r_pixels;
                        r_out_valid  <= 1'b1;
                        r_state      <= B_IDLE;
                    end
                end
                default: begin
                    r_state <= B_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== design/log_average_luminance.sv =====
// Log-average luminance of a frame of HDR pixels, the key value of a tone-mapping operator.
// Push one RGB pixel per item (unsigned Q8.16 channels) and mark the final pixel of the frame
// with last_pixel; one result item per frame then appears on the output queue, holding
// exp2 of the rounded mean of log2(L + 1 LSB) in Q8.16, saturated, and the pixel count.
// The front end takes a pixel through an accept step, three weight multiplies on the shared
// luminance multiplier, a rounding step, the binary-search normalizer, one step of the log2
// squaring multiplier per fraction bit and a step to hand the log2 value on; the front end
// takes no new pixel until that value has gone into the queue, and a full queue holds it. The
// frame back end adds each value to the sum and count; after the last one it sets up the
// divider, takes NUM_W quotient bits, fixes the sign, does the FRAC_BITS exp2 multiplies and
// loads the output register once it is free or being popped. A four-entry queue between the
// two halves lets the next frame's pixels flow while the previous frame's mean is still being
// worked out. Pixels beyond MAX_PIXELS in a frame are dropped from the sum and the count, but
// a dropped last pixel still closes the frame.

`default_nettype none

module log_average_luminance (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       push,
    output logic                       full,
    input  logic [lal_pkg::CHAN_W-1:0] i_red,
    input  logic [lal_pkg::CHAN_W-1:0] i_green,
    input  logic [lal_pkg::CHAN_W-1:0] i_blue,
    input  logic                       i_last_pixel,
    output logic                       empty,
    input  logic                       pop,
    output logic [lal_pkg::OUT_W-1:0]  o_average_luminance,
    output logic [lal_pkg::PIX_W-1:0]  o_frame_pixels
);
    import lal_pkg::*;

    // Handoff between the log2 front end and the queue.
    logic      front_push;
    logic      q_full;
    t_mid_item front_item;

    // Handoff between the queue and the frame back end.
    logic      q_pop;
    logic      q_empty;
    t_mid_item q_item;

    // The front end turns each pixel into its log2 luminance.
    lal_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_red        (i_red),
        .i_green      (i_green),
        .i_blue       (i_blue),
        .i_last_pixel (i_last_pixel),
        .o_full       (full),
        .o_q_push     (front_push),
        .i_q_full     (q_full),
        .o_q_item     (front_item)
    );

    // Short queue that lets the front end keep going while the back end divides.
    lal_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_item  (front_item),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_item  (q_item),
        .o_empty (q_empty)
    );

    // The back end accumulates, takes the mean, raises two to it and holds the result.
    lal_back u_back (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_q_item            (q_item),
        .i_q_empty           (q_empty),
        .o_q_pop             (q_pop),
        .i_pop               (pop),
        .o_empty             (empty),
        .o_average_luminance (o_average_luminance),
        .o_frame_pixels      (o_frame_pixels)
    );

endmodule

`default_nettype wire

// ===== design/lal_checker.sv =====
`default_nettype none

module lal_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       push,
    input logic                       full,
    input logic                       empty,
    input logic                       pop,
    input logic [lal_pkg::OUT_W-1:0]  o_average_luminance,
    input logic [lal_pkg::PIX_W-1:0]  o_frame_pixels
);

    // Reset leaves no result waiting.
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("result queue not empty after reset");

    // Reset leaves the front end ready for a pixel.
    a_reset_ready: assert property (@(posedge i_clk) !i_rst_n |=> !full)
        else $error("input side full after reset");

    // The front end works on one pixel at a time.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !full) |=> full)
        else $error("front end took a pixel without going busy");

    // A waiting result holds until it is taken.
    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_average_luminance)
                              && $stable(o_frame_pixels)))
        else $error("waiting result changed or vanished");

    // Every result counts at least one pixel.
    a_count_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_frame_pixels != '0))
        else $error("result with zero pixels");

endmodule

bind log_average_luminance lal_checker u_lal_checker (
    .i_clk               (i_clk),
    .i_rst_n             (i_rst_n),
    .push                (push),
    .full                (full),
    .empty               (empty),
    .pop                 (pop),
    .o_average_luminance (o_average_luminance),
    .o_frame_pixels      (o_frame_pixels)
);

`default_nettype wire
